@@ src/bht_pkg.sv @@
// Shared types and constants for the bone hierarchy transform core.
// Used by hbt_mac and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bht_pkg;

	localparam int NUM_CFG = 8;
	localparam int CFG_AW  = 6;

	localparam logic [1:0] SRC_MEM  = 2'd0;
	localparam logic [1:0] SRC_PRE  = 2'd1;
	localparam logic [1:0] SRC_ZERO = 2'd2;

	typedef logic [3:0][31:0] row_t;

	typedef struct packed {
		logic       clear;
		logic       issue;
		logic [3:0] idx;
		logic [1:0] src;
	} mac_ctl_t;

	typedef struct packed {
		logic v_s1;
		logic v_s2;
	} mac_stat_t;

endpackage

`default_nettype wire

@@ src/hbt_mem.sv @@
// Combined-matrix store: one write port, one read port, registered read data.
// No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module hbt_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [31:0]   wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [31:0]   rdata
);

	logic [31:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ src/hbt_mac.sv @@
// Multiply-accumulate datapath: one parent element per beat, four column
// accumulators, rounding and saturation. Depends on bht_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hbt_mac #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bht_pkg::mac_ctl_t ctl,
	input  wire logic [31:0]       pre_elem,
	input  wire logic [31:0]       mem_rdata,
	input  wire bht_pkg::row_t     local_row,
	output bht_pkg::mac_stat_t     stat,
	output bht_pkg::row_t          result
);
	import bht_pkg::*;

	localparam logic signed [65:0] HALF   = 66'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
	localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

	logic                v_s1;
	logic [3:0]          idx_s1;
	logic [1:0]          src_s1;
	logic [31:0]         pre_s1;
	logic                v_s2;
	logic [1:0]          col_s2;
	logic signed [63:0]  prod_s2;
	logic signed [31:0]  elem;
	logic signed [31:0]  lelem;
	logic signed [63:0]  prod;
	logic signed [65:0]  acc_q [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= ctl.idx;
		src_s1  <= ctl.src;
		pre_s1  <= pre_elem;
		col_s2  <= idx_s1[1:0];
		prod_s2 <= prod;
	end

	always_comb begin
		unique case (src_s1)
			SRC_MEM: elem = $signed(mem_rdata);
			SRC_PRE: elem = $signed(pre_s1);
			default: elem = '0;
		endcase
		lelem = $signed(local_row[idx_s1[3:2]]);
		prod  = lelem * elem;
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			for (int c = 0; c < 4; c++) begin
				acc_q[c] <= '0;
			end
		end else if (v_s2) begin
			acc_q[col_s2] <= acc_q[col_s2] + 66'(prod_s2);
		end
	end

	always_comb begin
		logic signed [65:0] t;
		logic signed [65:0] sh;
		for (int c = 0; c < 4; c++) begin
			t  = acc_q[c] + HALF;
			sh = t >>> FRAC_BITS;
			if (sh > SAT_HI) begin
				result[c] = SAT_HI[31:0];
			end else if (sh < SAT_LO) begin
				result[c] = SAT_LO[31:0];
			end else begin
				result[c] = sh[31:0];
			end
		end
	end

	assign stat.v_s1 = v_s1;
	assign stat.v_s2 = v_s2;

endmodule

`default_nettype wire

@@ src/bone_hierarchy_transform_core.sv @@
// Top level of the bone hierarchy transform core: command port, APB
// pre-transform registers and sequencer. Depends on bht_pkg, hbt_mem, hbt_mac.
//
// Usage:
//   Command channel: an item (bone, parent, row, four local elements) is taken
//   at a rising edge with start high and busy low. Result channel: done is
//   high for one cycle with out_bone, out_row and comb_e0..3; the receiver
//   cannot stall it, so sample on that cycle.
//   Config: APB with 64-bit data, register i at byte address 8*i; pready is
//   tied high. Write the pre-transform only while busy is low.
//   Sequencing: the sixteen parent elements are taken one per cycle (the
//   store has one read port), then the pipeline drains, done rises, and the
//   four elements are written back into the same store; busy stays high
//   until write-back ends, so a new item is taken only after that.
//   Parents must be sent before their children; the store holds no reset
//   value. Reset clears the sequencer and pre-transform registers (to zero);
//   no clearing pass is needed, the block is ready right after reset.
//   Root bones (negative parent) use the pre-transform; a parent at or beyond
//   MAX_BONES gives a zero row; a bone at or beyond MAX_BONES is not stored.
`timescale 1ns / 1ps
`default_nettype none

module bone_hierarchy_transform_core #(
	parameter int MAX_BONES = 256,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic        [7:0]           bone_index,
	input  wire logic signed [8:0]           parent_index,
	input  wire logic        [1:0]           row_index,
	input  wire logic signed [31:0]          local_e0,
	input  wire logic signed [31:0]          local_e1,
	input  wire logic signed [31:0]          local_e2,
	input  wire logic signed [31:0]          local_e3,
	output logic                             done,
	output logic             [7:0]           out_bone,
	output logic             [1:0]           out_row,
	output logic signed      [31:0]          comb_e0,
	output logic signed      [31:0]          comb_e1,
	output logic signed      [31:0]          comb_e2,
	output logic signed      [31:0]          comb_e3,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [bht_pkg::CFG_AW-1:0]  paddr,
	input  wire logic [63:0]                 pwdata,
	output logic      [63:0]                 prdata,
	output logic                             pready
);
	import bht_pkg::*;

	localparam int BW    = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
	localparam int AW    = BW + 4;
	localparam int DEPTH = MAX_BONES * 16;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RD    = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_WR    = 2'd3;

	logic [1:0]        state_q;
	logic [3:0]        cnt_q;
	logic [1:0]        wcnt_q;
	logic              done_q;
	logic [7:0]        bone_q;
	logic [8:0]        parent_q;
	logic [1:0]        row_q;
	row_t              local_q;
	row_t              res_q;
	logic [63:0]       pre_q [NUM_CFG];
	logic [63:0]       pre_word;
	logic [31:0]       pre_elem;
	logic              accept;
	logic              cfg_wr;
	logic              parent_ok;
	logic              bone_ok;
	mac_ctl_t          ctl;
	mac_stat_t         stat;
	row_t              mac_res;
	logic [31:0]       rdata;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [AW-1:0]     raddr;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign pready    = 1'b1;
	assign prdata    = pre_q[paddr[5:3]];
	assign parent_ok = !parent_q[8] && (32'(parent_q[7:0]) < MAX_BONES);
	assign bone_ok   = (32'(bone_q) < MAX_BONES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CFG; i++) begin
				pre_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			pre_q[paddr[5:3]] <= pwdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			wcnt_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RD;
						cnt_q   <= '0;
					end
				end
				ST_RD: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!stat.v_s1 && !stat.v_s2) begin
						state_q <= ST_WR;
						wcnt_q  <= '0;
						done_q  <= 1'b1;
					end
				end
				ST_WR: begin
					wcnt_q <= wcnt_q + 2'd1;
					if (wcnt_q == 2'd3) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bone_q     <= bone_index;
			parent_q   <= parent_index;
			row_q      <= row_index;
			local_q[0] <= local_e0;
			local_q[1] <= local_e1;
			local_q[2] <= local_e2;
			local_q[3] <= local_e3;
		end
		if (state_q == ST_DRAIN && !stat.v_s1 && !stat.v_s2) begin
			res_q <= mac_res;
		end
	end

	assign pre_word = pre_q[{cnt_q[3:2], cnt_q[1]}];
	assign pre_elem = cnt_q[0] ? pre_word[63:32] : pre_word[31:0];

	always_comb begin
		ctl.clear = accept;
		ctl.issue = (state_q == ST_RD);
		ctl.idx   = cnt_q;
		if (parent_q[8]) begin
			ctl.src = SRC_PRE;
		end else if (parent_ok) begin
			ctl.src = SRC_MEM;
		end else begin
			ctl.src = SRC_ZERO;
		end
	end

	assign raddr = {BW'(parent_q[7:0]), cnt_q};
	assign waddr = {BW'(bone_q), row_q, wcnt_q};
	assign we    = (state_q == ST_WR) && bone_ok;

	hbt_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (res_q[wcnt_q]),
		.re    (ctl.issue && (ctl.src == SRC_MEM)),
		.raddr (raddr),
		.rdata (rdata)
	);

	hbt_mac #(
		.FRAC_BITS (FRAC_BITS)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.pre_elem  (pre_elem),
		.mem_rdata (rdata),
		.local_row (local_q),
		.stat      (stat),
		.result    (mac_res)
	);

	assign done     = done_q;
	assign out_bone = bone_q;
	assign out_row  = row_q;
	assign comb_e0  = $signed(res_q[0]);
	assign comb_e1  = $signed(res_q[1]);
	assign comb_e2  = $signed(res_q[2]);
	assign comb_e3  = $signed(res_q[3]);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##20 done)
		else $error("result strobe not at fixed latency");

	a_done_wr: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == ST_WR) && (wcnt_q == 2'd0))
		else $error("result strobe outside first write-back beat");

	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one beat");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !stat.v_s1 && !stat.v_s2)
		else $error("datapath busy while sequencer idle");

endmodule

`default_nettype wire

@@ sim/tb_bone_hierarchy_transform_core.sv @@
// Self-checking bench for bone_hierarchy_transform_core: row commands and APB
// pre-transform writes come from a plan queue, every done beat is checked
// against a local forward-kinematics predictor. Depends on bht_pkg and the core.
`timescale 1ns / 1ps

module tb_bone_hierarchy_transform_core;
	import bht_pkg::*;

	localparam int MAX_BONES = 256;
	localparam int FRAC_BITS = 16;
	localparam int ADDR_W = CFG_AW;
	localparam int RAND_ITEMS = 1430;
	localparam int STALL_LIMIT = 1000;
	localparam int TAIL_CYCLES = 30;
	localparam longint ROUND_HALF = longint'(1) << (FRAC_BITS - 1);
	localparam logic signed [79:0] SAT_HI = 80'sh7fff_ffff;
	localparam logic signed [79:0] SAT_LO = -80'sh8000_0000;
	localparam logic signed [8:0] ROOT = -9'sd1;
	localparam logic signed [8:0] NEG_MOST = -9'sd256;
	localparam logic [31:0] ONE = 32'h0001_0000;
	localparam logic [31:0] HALF = 32'h0000_8000;
	localparam logic [31:0] NHALF = 32'hffff_8000;
	localparam logic [31:0] MAXV = 32'h7fff_ffff;
	localparam logic [31:0] MINV = 32'h8000_0000;
	localparam logic [31:0] NEG1 = 32'hffff_ffff;

	typedef enum int {
		REG_PRE_ROW0_LO, REG_PRE_ROW0_HI, REG_PRE_ROW1_LO, REG_PRE_ROW1_HI,
		REG_PRE_ROW2_LO, REG_PRE_ROW2_HI, REG_PRE_ROW3_LO, REG_PRE_ROW3_HI
	} pre_reg_e;

	typedef enum logic [1:0] {OP_ROW, OP_CFG, OP_DRAIN} plan_op_e;
	typedef enum logic [2:0] {
		CFG_ZERO, CFG_IDENT, CFG_MAX, CFG_MIN, CFG_ONES, CFG_RAND, CFG_POSE
	} cfg_kind_e;
	typedef enum logic [2:0] {
		D_FETCH, D_GAP, D_CMD, D_QUIET, D_ACCESS, D_WRITE, D_END
	} drv_state_e;

	typedef struct {
		plan_op_e kind;
		int unsigned gap;
		bit idle_only;
		logic [7:0] bone;
		logic signed [8:0] parent;
		logic [1:0] row;
		row_t loc;
		logic [ADDR_W-1:0] addr;
		logic [63:0] value;
	} plan_beat_t;

	typedef struct packed {
		logic [7:0] bone;
		logic [1:0] row;
		row_t comb;
	} pose_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [7:0] bone_index = '0;
	logic signed [8:0] parent_index = '0;
	logic [1:0] row_index = '0;
	logic signed [31:0] local_e0 = '0;
	logic signed [31:0] local_e1 = '0;
	logic signed [31:0] local_e2 = '0;
	logic signed [31:0] local_e3 = '0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic busy;
	logic done;
	logic [7:0] out_bone;
	logic [1:0] out_row;
	logic signed [31:0] comb_e0;
	logic signed [31:0] comb_e1;
	logic signed [31:0] comb_e2;
	logic signed [31:0] comb_e3;
	logic [63:0] prdata;
	logic pready;

	plan_beat_t cmd_plan[$];
	plan_beat_t cur;
	drv_state_e dst = D_FETCH;
	logic cmd_taken = 1'b0;
	logic wr_taken = 1'b0;

	pose_row_t rows_due[$];
	logic [63:0] pre_bank[NUM_CFG] = '{default: '0};
	logic [31:0] world_rows[MAX_BONES * 16];

	logic [3:0] gen_mask[MAX_BONES] = '{default: '0};
	bit gen_ready[MAX_BONES] = '{default: 1'b0};
	int ready_bones[$];
	bit calm = 1'b0;
	int made = 0;
	cfg_kind_e cfg_plan[8] = '{CFG_POSE, CFG_MAX, CFG_RAND, CFG_MIN,
		CFG_ONES, CFG_ZERO, CFG_IDENT, CFG_POSE};

	int errors = 0;
	int beats_in = 0;
	int root_rows = 0;
	int self_rows = 0;
	int rows_checked = 0;
	int cfg_writes = 0;
	int sat_elems = 0;
	int quiet_cycles = 0;

	bone_hierarchy_transform_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.bone_index(bone_index),
		.parent_index(parent_index),
		.row_index(row_index),
		.local_e0(local_e0),
		.local_e1(local_e1),
		.local_e2(local_e2),
		.local_e3(local_e3),
		.done(done),
		.out_bone(out_bone),
		.out_row(out_row),
		.comb_e0(comb_e0),
		.comb_e1(comb_e1),
		.comb_e2(comb_e2),
		.comb_e3(comb_e3),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	function automatic row_t mk_row(logic [31:0] e0, logic [31:0] e1,
			logic [31:0] e2, logic [31:0] e3);
		row_t v;
		v[0] = e0;
		v[1] = e1;
		v[2] = e2;
		v[3] = e3;
		return v;
	endfunction

	// local row times the parent (or pre-transform) matrix, round half up, saturate
	function automatic row_t chain_row(logic signed [8:0] parent, row_t loc);
		row_t res;
		logic signed [31:0] pe;
		logic signed [79:0] acc;
		longint prod;
		for (int c = 0; c < 4; c++) begin
			acc = ROUND_HALF;
			for (int r = 0; r < 4; r++) begin
				if (parent < 0) begin
					pe = (c % 2 == 1) ? pre_bank[r * 2 + c / 2][63:32]
						: pre_bank[r * 2 + c / 2][31:0];
				end else if (int'(parent) >= MAX_BONES) begin
					pe = '0;
				end else begin
					pe = world_rows[int'(parent) * 16 + r * 4 + c];
				end
				prod = longint'($signed(loc[r])) * longint'(pe);
				acc = acc + prod;
			end
			acc = acc >>> FRAC_BITS;
			if (acc > SAT_HI) begin
				res[c] = MAXV;
			end else if (acc < SAT_LO) begin
				res[c] = MINV;
			end else begin
				res[c] = acc[31:0];
			end
		end
		return res;
	endfunction

	function automatic logic [31:0] make_elem();
		int dice;
		dice = $urandom_range(0, 9);
		if (dice < 6) return 32'(int'($urandom_range(0, 32'h3ffff)) - 32'h20000);
		if (dice < 8) return 32'($urandom);
		if (dice == 9) return 32'(int'($urandom_range(0, 32'h1ffffff)) - 32'h100_0000);
		case ($urandom_range(0, 5))
			0: return MAXV;
			1: return MINV;
			2: return NEG1;
			3: return ONE;
			4: return HALF;
			default: return '0;
		endcase
	endfunction

	function automatic row_t make_row();
		return mk_row(make_elem(), make_elem(), make_elem(), make_elem());
	endfunction

	function automatic logic [31:0] cfg_elem(cfg_kind_e kind, int r, int c);
		case (kind)
			CFG_IDENT: return (r == c) ? ONE : '0;
			CFG_MAX: return MAXV;
			CFG_MIN: return MINV;
			CFG_ONES: return NEG1;
			CFG_RAND: return 32'($urandom);
			CFG_POSE: begin
				if (r == 3 && c == 3) return ONE;
				if (r == 3) return 32'(int'($urandom_range(0, 32'h1ffffff)) - 32'h100_0000);
				return 32'(int'($urandom_range(0, 32'h3ffff)) - 32'h20000);
			end
			default: return '0;
		endcase
	endfunction

	// only fully written bones may be named as parents
	function automatic logic signed [8:0] pick_parent(logic [7:0] b);
		int k;
		k = $urandom_range(0, 19);
		if (k == 0) return 9'($urandom_range(256, 511));
		if (k < 5 || ready_bones.size() == 0) return ROOT;
		if (k == 5 && gen_ready[b]) return 9'(b);
		return 9'(ready_bones[$urandom_range(0, ready_bones.size() - 1)]);
	endfunction

	task automatic push_item(input logic [7:0] b, input logic signed [8:0] p,
			input logic [1:0] r, input row_t loc);
		plan_beat_t e;
		if ($urandom_range(0, 63) == 0) calm = !calm;
		e.kind = OP_ROW;
		e.gap = calm ? 0 : $urandom_range(0, 16);
		e.idle_only = 1'($urandom_range(0, 1));
		e.bone = b;
		e.parent = p;
		e.row = r;
		e.loc = loc;
		e.addr = '0;
		e.value = '0;
		cmd_plan.push_back(e);
		gen_mask[b][r] = 1'b1;
		if (gen_mask[b] == 4'hf && !gen_ready[b]) begin
			gen_ready[b] = 1'b1;
			ready_bones.push_back(int'(b));
		end
		made++;
	endtask

	task automatic push_config(input cfg_kind_e kind);
		plan_beat_t e;
		for (int i = REG_PRE_ROW0_LO; i <= REG_PRE_ROW3_HI; i++) begin
			e.kind = OP_CFG;
			e.gap = $urandom_range(0, 16);
			e.idle_only = 1'b0;
			e.bone = '0;
			e.parent = '0;
			e.row = '0;
			e.loc = '0;
			e.addr = ADDR_W'(i * 8);
			e.value = {cfg_elem(kind, i / 2, (i % 2) * 2 + 1), cfg_elem(kind, i / 2, (i % 2) * 2)};
			cmd_plan.push_back(e);
		end
	endtask

	task automatic push_drain();
		plan_beat_t e;
		e.kind = OP_DRAIN;
		e.gap = 0;
		e.idle_only = 1'b0;
		e.bone = '0;
		e.parent = '0;
		e.row = '0;
		e.loc = '0;
		e.addr = '0;
		e.value = '0;
		cmd_plan.push_back(e);
	endtask

	initial begin
		int shape;
		int nrows;
		int first;
		int phase_end;
		logic [7:0] b;
		logic signed [8:0] p;

		// pre-transform still at reset: roots come out zero
		push_item(8'd0, ROOT, 2'd0, mk_row(MAXV, MINV, '0, NEG1));
		push_item(8'd0, ROOT, 2'd1, mk_row(MINV, MAXV, NEG1, '0));
		push_item(8'd0, ROOT, 2'd2, mk_row(NEG1, '0, MAXV, MINV));
		push_item(8'd0, ROOT, 2'd3, mk_row('0, NEG1, MINV, MAXV));
		push_config(CFG_IDENT);
		push_item(8'd1, ROOT, 2'd0, mk_row(ONE, '0, '0, '0));
		push_item(8'd1, ROOT, 2'd1, mk_row('0, ONE, '0, '0));
		push_item(8'd1, ROOT, 2'd2, mk_row('0, '0, ONE, '0));
		push_item(8'd1, ROOT, 2'd3, mk_row('0, '0, '0, ONE));
		push_item(8'd2, 9'sd1, 2'd0, mk_row(MAXV, MINV, HALF, NHALF));
		push_item(8'd2, 9'sd1, 2'd1, mk_row(MINV, MAXV, 32'd1, NEG1));
		push_item(8'd2, 9'sd1, 2'd2, mk_row(ONE, ONE, ONE, ONE));
		push_item(8'd2, 9'sd1, 2'd3, mk_row('0, NEG1, MAXV, '0));
		// halves round up, then saturation both ways
		push_item(8'd3, 9'sd2, 2'd0, mk_row(32'd1, '0, '0, '0));
		push_item(8'd3, 9'sd2, 2'd1, mk_row(MAXV, MINV, '0, '0));
		push_item(8'd3, 9'sd2, 2'd2, mk_row(MINV, MINV, MINV, MINV));
		push_item(8'd3, 9'sd2, 2'd3, mk_row(MAXV, MAXV, MAXV, MAXV));
		// bone naming itself reads its rows as stored
		push_item(8'd3, 9'sd3, 2'd0, mk_row(ONE, '0, '0, '0));
		push_item(8'd3, 9'sd3, 2'd2, mk_row('0, '0, MAXV, ONE));
		// any negative parent selects the pre-transform
		push_item(8'd5, NEG_MOST, 2'd0, make_row());
		push_item(8'd255, -9'sd2, 2'd3, mk_row(ONE, ONE, ONE, ONE));
		push_drain();

		for (int ph = 0; ph < 8; ph++) begin
			push_config(cfg_plan[ph]);
			phase_end = made + RAND_ITEMS / 8;
			while (made < phase_end) begin
				shape = $urandom_range(0, 99);
				b = 8'($urandom_range(0, 255));
				p = pick_parent(b);
				nrows = (shape < 75) ? 4 : (shape < 90) ? $urandom_range(1, 3) : 0;
				if (nrows == 0) begin
					push_item(b, p, 2'($urandom_range(0, 3)), make_row());
				end else begin
					first = $urandom_range(0, 3);
					for (int k = 0; k < nrows; k++)
						push_item(b, p, 2'(first + k), make_row());
				end
				if ($urandom_range(0, 149) == 0) push_drain();
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (dst != D_END || rows_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (rows_due.size() != 0) begin
			errors += rows_due.size();
			$display("rows still outstanding at end: %0d", rows_due.size());
		end
		$display("covered %0d command beats (%0d root, %0d self-parent), %0d register writes",
			beats_in, root_rows, self_rows, cfg_writes);
		$display("checked %0d combined rows, %0d saturated elements, %0d mismatches",
			rows_checked, sat_elems, errors);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			case (dst)
				D_FETCH: begin
					if (cmd_plan.size() == 0) begin
						dst <= D_END;
					end else begin
						cur <= cmd_plan.pop_front();
						dst <= D_GAP;
					end
				end
				D_GAP: begin
					if (cur.gap != 0) begin
						if (!cur.idle_only || !busy) cur.gap <= cur.gap - 1;
					end else if (cur.kind == OP_ROW) begin
						start <= 1'b1;
						bone_index <= cur.bone;
						parent_index <= cur.parent;
						row_index <= cur.row;
						local_e0 <= cur.loc[0];
						local_e1 <= cur.loc[1];
						local_e2 <= cur.loc[2];
						local_e3 <= cur.loc[3];
						dst <= D_CMD;
					end else begin
						dst <= D_QUIET;
					end
				end
				D_CMD: if (cmd_taken) begin
					start <= 1'b0;
					dst <= D_FETCH;
				end
				// hold until every row is back and the core is idle
				D_QUIET: if (rows_due.size() == 0 && !busy) begin
					if (cur.kind == OP_CFG) begin
						psel <= 1'b1;
						pwrite <= 1'b1;
						paddr <= cur.addr;
						pwdata <= cur.value;
						dst <= D_ACCESS;
					end else begin
						dst <= D_FETCH;
					end
				end
				D_ACCESS: begin
					penable <= 1'b1;
					dst <= D_WRITE;
				end
				D_WRITE: if (wr_taken) begin
					psel <= 1'b0;
					penable <= 1'b0;
					pwrite <= 1'b0;
					dst <= D_FETCH;
				end
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		pose_row_t want;
		if (!arst_n) begin
			cmd_taken <= 1'b0;
			wr_taken <= 1'b0;
		end else begin
			cmd_taken <= start && !busy;
			wr_taken <= psel && penable && pwrite && pready;
			if (done) begin
				rows_checked++;
				if (rows_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected row beat: bone %0d row %0d", out_bone, out_row);
				end else begin
					want = rows_due.pop_front();
					if (out_bone !== want.bone || out_row !== want.row
							|| comb_e0 !== want.comb[0] || comb_e1 !== want.comb[1]
							|| comb_e2 !== want.comb[2] || comb_e3 !== want.comb[3]) begin
						errors++;
						if (errors <= 10)
							$display("row mismatch: expected %0d/%0d %h %h %h %h, got %0d/%0d %h %h %h %h",
								want.bone, want.row, want.comb[0], want.comb[1], want.comb[2],
								want.comb[3], out_bone, out_row, comb_e0, comb_e1, comb_e2, comb_e3);
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				pre_bank[paddr[ADDR_W-1:3]] = pwdata;
				cfg_writes++;
			end
			if (start && !busy) begin
				want.bone = bone_index;
				want.row = row_index;
				want.comb = chain_row(parent_index, mk_row(local_e0, local_e1, local_e2, local_e3));
				if (int'(bone_index) < MAX_BONES) begin
					for (int c = 0; c < 4; c++)
						world_rows[int'(bone_index) * 16 + int'(row_index) * 4 + c] = want.comb[c];
				end
				for (int c = 0; c < 4; c++)
					if (want.comb[c] == MAXV || want.comb[c] == MINV) sat_elems++;
				beats_in++;
				if (parent_index < 0) root_rows++;
				if (parent_index == $signed({1'b0, bone_index})) self_rows++;
				rows_due.push_back(want);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable && pwrite && pready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", STALL_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

endmodule
